### rtl/core/priority_bitmap_ready_queue_defines.svh
// Assertion macros for the ready queue RTL.
// Expect signals clk and rst_n in the scope of use; no other dependencies.
`ifndef PRIORITY_BITMAP_READY_QUEUE_DEFINES_SVH
`define PRIORITY_BITMAP_READY_QUEUE_DEFINES_SVH
`ifndef SYNTHESIS
`define PBRQ_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pbrq assertion failed");
`define PBRQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pbrq assertion failed");
`else
`define PBRQ_ASSERT_IMPL(label, ante, cons)
`define PBRQ_ASSERT_NEXT(label, ante, cons)
`endif
`endif

### rtl/core/pbrq_pkg.sv
// Package for the ready queue: request codes, field widths, word layout.
// No dependencies.
`default_nettype none
package pbrq_pkg;

    localparam int PBRQ_LEVELS = 32;
    localparam int PBRQ_TASKS  = 64;

    localparam int REQ_W   = 3;
    localparam int TASK_W  = 6;
    localparam int PRIO_W  = 5;
    localparam int POS_W   = 6;

    // input word layout, lowest bit first
    localparam int REQ_LSB   = 0;
    localparam int TASK_LSB  = REQ_LSB + REQ_W;
    localparam int PRIO_LSB  = TASK_LSB + TASK_W;
    localparam int NPRIO_LSB = PRIO_LSB + PRIO_W;
    localparam int POS_LSB   = NPRIO_LSB + PRIO_W;
    localparam int IN_BITS   = POS_LSB + POS_W;
    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS    = 1 + TASK_W + 1 + 1;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [REQ_W-1:0] REQ_ADD     = 3'd0;
    localparam logic [REQ_W-1:0] REQ_REMOVE  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_REQUEUE = 3'd2;
    localparam logic [REQ_W-1:0] REQ_DEQ     = 3'd3;
    localparam logic [REQ_W-1:0] REQ_PEEK    = 3'd4;
    localparam logic [REQ_W-1:0] REQ_POS     = 3'd5;
    localparam logic [REQ_W-1:0] REQ_WBF     = 3'd6;

endpackage
`default_nettype wire

### rtl/core/pbrq_ram.sv
// Simple dual-port RAM: one write port, one registered read port.
// Depends on nothing.
`default_nettype none
module pbrq_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 7
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

### rtl/core/pbrq_top_enc.sv
// Highest-set-bit encoder, shared by top-level lookup and position scan.
// Depends on nothing.
`default_nettype none
module pbrq_top_enc #(
    parameter int N = 32
) (
    input  wire logic [N-1:0]         vec,
    output logic                      any,
    output logic [$clog2(N)-1:0]      idx
);
    always_comb
    begin
        any = 1'b0;
        idx = '0;
        for (int i = 0; i < N; i++)
        begin
            if (vec[i])
            begin
                any = 1'b1;
                idx = ($clog2(N))'(i);
            end
        end
    end
endmodule
`default_nettype wire

### rtl/core/priority_bitmap_ready_queue.sv
// Priority ready queue: per-level doubly linked FIFOs plus occupancy bitmap.
// Each request walks its own sequence of states before the result is offered;
// position walks occupied levels from the top, stepping node by node. One word
// in flight. Reset (async, rst_n low) clears the occupancy bitmap and handshake
// state; list RAMs are not cleared, so a list entry must only be read after being
// written, which the user must see to: the block itself does not enforce it.
`default_nettype none
module priority_bitmap_ready_queue
    import pbrq_pkg::*;
#(
    parameter int PRIORITY_LEVELS = PBRQ_LEVELS,
    parameter int MAX_TASKS       = PBRQ_TASKS
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // tdata: req_type[2:0], task_id[8:3], priority_req[13:9], new_priority[18:14],
    //        position[24:19], zero pad
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,
    // tdata: found[0], result_task[6:1], would_be_first[7], status[8], zero pad
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [OUT_TDATA_W-1:0]      m_tdata
);

`include "priority_bitmap_ready_queue_defines.svh"

    localparam int LVW = $clog2(PRIORITY_LEVELS);
    localparam int TW  = $clog2(MAX_TASKS);
    localparam int LW  = $clog2(MAX_TASKS + 1);  // link: task id or null mark
    localparam logic [LW-1:0] NIL = LW'(MAX_TASKS);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_ADD_RD   = 4'd1;
    localparam logic [3:0] S_ADD_W1   = 4'd2;
    localparam logic [3:0] S_ADD_W2   = 4'd3;
    localparam logic [3:0] S_UNL_RD   = 4'd4;
    localparam logic [3:0] S_UNL_WR   = 4'd5;
    localparam logic [3:0] S_INS_RD   = 4'd6;
    localparam logic [3:0] S_INS_W1   = 4'd7;
    localparam logic [3:0] S_INS_W2   = 4'd8;
    localparam logic [3:0] S_TOP_RD   = 4'd9;
    localparam logic [3:0] S_TOP_CHK  = 4'd10;
    localparam logic [3:0] S_DEQ_WR   = 4'd11;
    localparam logic [3:0] S_POS_LVL  = 4'd12;
    localparam logic [3:0] S_POS_NODE = 4'd13;
    localparam logic [3:0] S_DONE     = 4'd14;

    function automatic logic is_task(input logic [LW-1:0] l);
        return l < NIL;
    endfunction

    // input field split
    logic [REQ_W-1:0]  in_req;
    logic [TASK_W-1:0] in_task;
    logic [PRIO_W-1:0] in_prio;
    logic [PRIO_W-1:0] in_nprio;
    logic [POS_W-1:0]  in_pos;
    logic              in_task_ok;
    logic              in_prio_ok;
    logic              in_nprio_ok;
    logic [LVW-1:0]    in_lvl;

    assign in_req   = s_tdata[REQ_LSB +: REQ_W];
    assign in_task  = s_tdata[TASK_LSB +: TASK_W];
    assign in_prio  = s_tdata[PRIO_LSB +: PRIO_W];
    assign in_nprio = s_tdata[NPRIO_LSB +: PRIO_W];
    assign in_pos   = s_tdata[POS_LSB +: POS_W];
    assign in_task_ok  = 32'(in_task) < 32'(MAX_TASKS);
    assign in_prio_ok  = 32'(in_prio) < 32'(PRIORITY_LEVELS);
    assign in_nprio_ok = 32'(in_nprio) < 32'(PRIORITY_LEVELS);
    assign in_lvl      = LVW'(in_prio);

    // control state
    logic [3:0]                 state_reg, state_next;
    logic [PRIORITY_LEVELS-1:0] occ_reg, occ_next;
    logic                       out_valid_reg, out_valid_next;

    // request and working registers
    logic [REQ_W-1:0]           req_reg, req_next;
    logic [TW-1:0]              t_reg, t_next;
    logic [LVW-1:0]             p_reg, p_next;
    logic [LVW-1:0]             np_reg, np_next;
    logic [POS_W-1:0]           pos_reg, pos_next;
    logic [LVW-1:0]             lvl_reg, lvl_next;
    logic [LW-1:0]              link_reg, link_next;
    logic                       cond_reg, cond_next;
    logic [LW-1:0]              cnt_reg, cnt_next;
    logic [PRIORITY_LEVELS-1:0] scan_reg, scan_next;
    logic                       src_head_reg, src_head_next;
    logic                       res_found_reg, res_found_next;
    logic [TASK_W-1:0]          res_task_reg, res_task_next;
    logic                       res_wbf_reg, res_wbf_next;
    logic                       res_status_reg, res_status_next;
    logic [OUT_BITS-1:0]        out_reg, out_next;

    // list RAM ports
    logic           hd_we, tl_we, nx_we, pv_we;
    logic [LVW-1:0] hd_wa, tl_wa, hd_ra;
    logic [TW-1:0]  nx_wa, pv_wa, nx_ra;
    logic [LW-1:0]  hd_wd, tl_wd, nx_wd, pv_wd;
    logic [LW-1:0]  hd_rd, tl_rd, nx_rd, pv_rd;

    // shared top-level encoder
    logic [PRIORITY_LEVELS-1:0] enc_vec;
    logic                       enc_any;
    logic [LVW-1:0]             enc_idx;

    logic [LW-1:0] t_link;
    logic [LW-1:0] node;
    logic [LW-1:0] new_head;

    assign t_link = LW'(t_reg);
    assign node   = src_head_reg ? hd_rd : nx_rd;
    assign new_head = is_task(pv_rd) ? hd_rd : nx_rd;

    pbrq_top_enc #(.N(PRIORITY_LEVELS)) u_enc (
        .vec (enc_vec),
        .any (enc_any),
        .idx (enc_idx)
    );

    pbrq_ram #(.DEPTH(PRIORITY_LEVELS), .WIDTH(LW)) u_head (
        .clk   (clk),
        .we    (hd_we),
        .waddr (hd_wa),
        .wdata (hd_wd),
        .raddr (hd_ra),
        .rdata (hd_rd)
    );

    pbrq_ram #(.DEPTH(PRIORITY_LEVELS), .WIDTH(LW)) u_tail (
        .clk   (clk),
        .we    (tl_we),
        .waddr (tl_wa),
        .wdata (tl_wd),
        .raddr (p_reg),
        .rdata (tl_rd)
    );

    pbrq_ram #(.DEPTH(MAX_TASKS), .WIDTH(LW)) u_next (
        .clk   (clk),
        .we    (nx_we),
        .waddr (nx_wa),
        .wdata (nx_wd),
        .raddr (nx_ra),
        .rdata (nx_rd)
    );

    pbrq_ram #(.DEPTH(MAX_TASKS), .WIDTH(LW)) u_prev (
        .clk   (clk),
        .we    (pv_we),
        .waddr (pv_wa),
        .wdata (pv_wd),
        .raddr (t_reg),
        .rdata (pv_rd)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_TDATA_W'(out_reg);

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        occ_next        = occ_reg;
        req_next        = req_reg;
        t_next          = t_reg;
        p_next          = p_reg;
        np_next         = np_reg;
        pos_next        = pos_reg;
        lvl_next        = lvl_reg;
        link_next       = link_reg;
        cond_next       = cond_reg;
        cnt_next        = cnt_reg;
        scan_next       = scan_reg;
        src_head_next   = src_head_reg;
        res_found_next  = res_found_reg;
        res_task_next   = res_task_reg;
        res_wbf_next    = res_wbf_reg;
        res_status_next = res_status_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && !m_tready;

        hd_we = 1'b0; hd_wa = p_reg;  hd_wd = NIL;
        tl_we = 1'b0; tl_wa = p_reg;  tl_wd = NIL;
        nx_we = 1'b0; nx_wa = t_reg;  nx_wd = NIL;
        pv_we = 1'b0; pv_wa = t_reg;  pv_wd = NIL;
        hd_ra = p_reg;
        nx_ra = t_reg;
        enc_vec = (state_reg == S_POS_LVL) ? (scan_reg & occ_reg) : occ_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    req_next        = in_req;
                    t_next          = TW'(in_task);
                    p_next          = in_lvl;
                    np_next         = LVW'(in_nprio);
                    pos_next        = in_pos;
                    cnt_next        = '0;
                    scan_next       = '1;
                    res_found_next  = 1'b0;
                    res_task_next   = '0;
                    res_wbf_next    = 1'b0;
                    res_status_next = 1'b0;
                    state_next      = S_DONE;
                    unique case (in_req) inside
                        REQ_ADD:
                        begin
                            if (in_task_ok && in_prio_ok)
                                state_next = S_ADD_RD;
                            else
                                res_status_next = 1'b1;
                        end
                        REQ_REMOVE:
                        begin
                            if (!(in_task_ok && in_prio_ok))
                                res_status_next = 1'b1;
                            else if (occ_reg[in_lvl])
                                state_next = S_UNL_RD;
                        end
                        REQ_REQUEUE:
                        begin
                            if (!(in_task_ok && in_prio_ok && in_nprio_ok))
                                res_status_next = 1'b1;
                            else if (occ_reg[in_lvl])
                                state_next = S_UNL_RD;
                            else
                                state_next = S_INS_RD;
                        end
                        REQ_DEQ, REQ_PEEK:
                        begin
                            state_next = S_TOP_RD;
                        end
                        REQ_POS:
                        begin
                            state_next = S_POS_LVL;
                        end
                        REQ_WBF:
                        begin
                            // empty queue, or strictly above the top level
                            res_wbf_next = !enc_any || (32'(in_prio) > 32'(enc_idx));
                        end
                        default:
                        begin
                            res_status_next = 1'b1;
                        end
                    endcase
                end
            end

            S_ADD_RD:
            begin
                state_next = S_ADD_W1;  // tail[p] read in flight
            end

            S_ADD_W1:
            begin
                cond_next = occ_reg[p_reg] && is_task(tl_rd);
                link_next = tl_rd;
                nx_we = 1'b1;
                pv_we = 1'b1;
                pv_wd = (occ_reg[p_reg] && is_task(tl_rd)) ? tl_rd : NIL;
                if (!(occ_reg[p_reg] && is_task(tl_rd)))
                begin
                    hd_we = 1'b1;
                    hd_wd = t_link;
                end
                tl_we = 1'b1;
                tl_wd = t_link;
                occ_next[p_reg] = 1'b1;
                state_next = S_ADD_W2;
            end

            S_ADD_W2:
            begin
                // old tail now points at the new task (after next[t] was nulled)
                if (cond_reg)
                begin
                    nx_we = 1'b1;
                    nx_wa = TW'(link_reg);
                    nx_wd = t_link;
                end
                state_next = S_DONE;
            end

            S_UNL_RD:
            begin
                state_next = S_UNL_WR;  // prev[t], next[t], head[p] in flight
            end

            S_UNL_WR:
            begin
                if (is_task(pv_rd))
                begin
                    nx_we = 1'b1;
                    nx_wa = TW'(pv_rd);
                    nx_wd = nx_rd;
                end
                else
                begin
                    hd_we = 1'b1;
                    hd_wd = nx_rd;
                end
                if (is_task(nx_rd))
                begin
                    pv_we = 1'b1;
                    pv_wa = TW'(nx_rd);
                    pv_wd = pv_rd;
                end
                else
                begin
                    tl_we = 1'b1;
                    tl_wd = pv_rd;
                end
                if (!is_task(new_head))
                    occ_next[p_reg] = 1'b0;
                state_next = (req_reg == REQ_REQUEUE) ? S_INS_RD : S_DONE;
            end

            S_INS_RD:
            begin
                hd_ra = np_reg;
                state_next = S_INS_W1;
            end

            S_INS_W1:
            begin
                cond_next = occ_reg[np_reg] && is_task(hd_rd);
                link_next = hd_rd;
                pv_we = 1'b1;
                nx_we = 1'b1;
                nx_wd = (occ_reg[np_reg] && is_task(hd_rd)) ? hd_rd : NIL;
                if (!(occ_reg[np_reg] && is_task(hd_rd)))
                begin
                    tl_we = 1'b1;
                    tl_wa = np_reg;
                    tl_wd = t_link;
                end
                hd_we = 1'b1;
                hd_wa = np_reg;
                hd_wd = t_link;
                occ_next[np_reg] = 1'b1;
                state_next = S_INS_W2;
            end

            S_INS_W2:
            begin
                if (cond_reg)
                begin
                    pv_we = 1'b1;
                    pv_wa = TW'(link_reg);
                    pv_wd = t_link;
                end
                state_next = S_DONE;
            end

            S_TOP_RD:
            begin
                if (!enc_any)
                begin
                    res_status_next = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    lvl_next = enc_idx;
                    hd_ra = enc_idx;
                    state_next = S_TOP_CHK;
                end
            end

            S_TOP_CHK:
            begin
                if (!is_task(hd_rd))
                begin
                    // occupied level with a bad head
                    occ_next[lvl_reg] = 1'b0;
                    res_status_next = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    res_found_next = 1'b1;
                    res_task_next = TASK_W'(hd_rd);
                    nx_ra = TW'(hd_rd);
                    state_next = (req_reg == REQ_DEQ) ? S_DEQ_WR : S_DONE;
                end
            end

            S_DEQ_WR:
            begin
                hd_we = 1'b1;
                hd_wa = lvl_reg;
                if (is_task(nx_rd))
                begin
                    hd_wd = nx_rd;
                    pv_we = 1'b1;
                    pv_wa = TW'(nx_rd);
                end
                else
                begin
                    occ_next[lvl_reg] = 1'b0;
                end
                state_next = S_DONE;
            end

            S_POS_LVL:
            begin
                if (!enc_any)
                begin
                    res_status_next = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    lvl_next = enc_idx;
                    hd_ra = enc_idx;
                    for (int i = 0; i < PRIORITY_LEVELS; i++)
                        scan_next[i] = scan_reg[i] && (LVW'(i) < enc_idx);
                    src_head_next = 1'b1;
                    state_next = S_POS_NODE;
                end
            end

            S_POS_NODE:
            begin
                if (!is_task(node))
                begin
                    state_next = S_POS_LVL;
                end
                else if (32'(cnt_reg) >= 32'(MAX_TASKS))
                begin
                    // walk bound reached: every later level stops at once
                    res_status_next = 1'b1;
                    state_next = S_DONE;
                end
                else if (32'(cnt_reg) == 32'(pos_reg))
                begin
                    res_found_next = 1'b1;
                    res_task_next = TASK_W'(node);
                    state_next = S_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                    nx_ra = TW'(node);
                    src_head_next = 1'b0;
                end
            end

            S_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_next = {res_status_reg, res_wbf_reg, res_task_reg, res_found_reg};
                    out_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            occ_reg       <= occ_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        t_reg          <= t_next;
        p_reg          <= p_next;
        np_reg         <= np_next;
        pos_reg        <= pos_next;
        lvl_reg        <= lvl_next;
        link_reg       <= link_next;
        cond_reg       <= cond_next;
        cnt_reg        <= cnt_next;
        scan_reg       <= scan_next;
        src_head_reg   <= src_head_next;
        res_found_reg  <= res_found_next;
        res_task_reg   <= res_task_next;
        res_wbf_reg    <= res_wbf_next;
        res_status_reg <= res_status_next;
        out_reg        <= out_next;
    end

    // one word at a time: an accepted word closes the input side
    `PBRQ_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
    // results are only issued from the completion state
    `PBRQ_ASSERT_IMPL(a_out_from_done, $rose(m_tvalid), $past(state_reg) == S_DONE)
    // position walk stays within its bound
    `PBRQ_ASSERT_IMPL(a_walk_bound, state_reg == S_POS_NODE, 32'(cnt_reg) <= 32'(MAX_TASKS))

endmodule
`default_nettype wire

### dv/tb_priority_bitmap_ready_queue.sv
// Testbench for the priority ready queue: drives request words, predicts each
// response with its own list model and checks it. Depends on pbrq_pkg and the RTL.
`default_nettype none
module tb_priority_bitmap_ready_queue;
    import pbrq_pkg::*;

    // lowest bit last: found sits in bit 0 of the result word
    typedef struct packed {
        bit       status;
        bit       wbf;
        bit [5:0] tid;
        bit       found;
    } resp_t;

    localparam logic [6:0] NIL = 7'd64;
    localparam logic [REQ_W-1:0] REQ_UNUSED = 3'd7;

    // Ready-queue model plus the list of responses still owed by the block.
    class pbrq_scoreboard;
        bit         occ[32];
        logic [6:0] head[32];
        logic [6:0] tail[32];
        logic [6:0] nxt[64];
        logic [6:0] prv[64];
        resp_t      owed[$];
        int         errors;

        function int top_level();
            for (int l = 31; l >= 0; l--)
                if (occ[l])
                    return l;
            return -1;
        endfunction

        function void unlink(int t, int p);
            logic [6:0] pr, nx;
            if (!occ[p])
                return;
            pr = prv[t];
            nx = nxt[t];
            if (pr < 64) nxt[pr[5:0]] = nx; else head[p] = nx;
            if (nx < 64) prv[nx[5:0]] = pr; else tail[p] = pr;
            if (head[p] >= 64)
                occ[p] = 0;
        endfunction

        function void put_tail(int t, int p);
            logic [6:0] tl;
            tl = tail[p];
            nxt[t] = NIL;
            if (occ[p] && tl < 64)
            begin
                prv[t] = tl;
                nxt[tl[5:0]] = 7'(t);
            end
            else
            begin
                prv[t] = NIL;
                head[p] = 7'(t);
            end
            tail[p] = 7'(t);
            occ[p] = 1;
        endfunction

        function void put_head(int t, int p);
            logic [6:0] hd;
            hd = head[p];
            prv[t] = NIL;
            if (occ[p] && hd < 64)
            begin
                nxt[t] = hd;
                prv[hd[5:0]] = 7'(t);
            end
            else
            begin
                nxt[t] = NIL;
                tail[p] = 7'(t);
            end
            head[p] = 7'(t);
            occ[p] = 1;
        endfunction

        // Note one accepted request word; returns the response it owes.
        function resp_t note_request(logic [2:0] req, int t, int p, int np, int ps);
            resp_t      r;
            int         top, cnt, steps;
            logic [6:0] hd, n;
            r = '0;
            case (req)
                REQ_ADD:     put_tail(t, p);
                REQ_REMOVE:  unlink(t, p);
                REQ_REQUEUE:
                begin
                    unlink(t, p);
                    put_head(t, np);
                end
                REQ_DEQ, REQ_PEEK:
                begin
                    top = top_level();
                    if (top < 0)
                        r.status = 1;
                    else
                    begin
                        hd = head[top];
                        if (hd >= 64)
                        begin
                            occ[top] = 0;
                            r.status = 1;
                        end
                        else
                        begin
                            r.found = 1;
                            r.tid = hd[5:0];
                            if (req == REQ_DEQ)
                            begin
                                n = nxt[hd[5:0]];
                                if (n < 64)
                                begin
                                    head[top] = n;
                                    prv[n[5:0]] = NIL;
                                end
                                else
                                begin
                                    head[top] = NIL;
                                    occ[top] = 0;
                                end
                            end
                        end
                    end
                end
                REQ_POS:
                begin
                    cnt = 0;
                    steps = 0;
                    for (int l = 31; l >= 0 && !r.found; l--)
                    begin
                        if (!occ[l])
                            continue;
                        n = head[l];
                        while (n < 64 && steps < 64)
                        begin
                            if (cnt == ps)
                            begin
                                r.found = 1;
                                r.tid = n[5:0];
                                break;
                            end
                            cnt++;
                            steps++;
                            n = nxt[n[5:0]];
                        end
                    end
                    r.status = !r.found;
                end
                REQ_WBF:
                begin
                    top = top_level();
                    r.wbf = (top < 0 || p > top);
                end
                default: r.status = 1;
            endcase
            owed.push_back(r);
            return r;
        endfunction

        function void check_response(resp_t got);
            resp_t e;
            if (owed.size() == 0)
            begin
                $error("response with nothing owed: %h", got);
                errors++;
                return;
            end
            e = owed.pop_front();
            if (got.found !== e.found)
            begin
                $error("found: expected %0d, got %0d", e.found, got.found);
                errors++;
            end
            if (got.tid !== e.tid)
            begin
                $error("result_task: expected %0d, got %0d", e.tid, got.tid);
                errors++;
            end
            if (got.wbf !== e.wbf)
            begin
                $error("would_be_first: expected %0d, got %0d", e.wbf, got.wbf);
                errors++;
            end
            if (got.status !== e.status)
            begin
                $error("status: expected %0d, got %0d", e.status, got.status);
                errors++;
            end
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;

    pbrq_scoreboard sb;
    int  lvl_of[64];     // level each task sits in, -1 when out of the queue
    bit  linked[64];     // task links have been written at least once
    bit  hold_rx;        // ask the receiver for a long hold-off
    bit  calm;           // phase with no idling on either side
    int  n_sent;

    priority_bitmap_ready_queue u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function int gap_len();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Offer one request word, wait for its acceptance, then at random idle a while.
    task send_request(logic [2:0] req, int t, int p, int np, int ps);
        resp_t r;
        int    g;
        s_tdata <= IN_TDATA_W'({6'(ps), 5'(np), 5'(p), 6'(t), req});
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        r = sb.note_request(req, t, p, np, ps);
        n_sent++;
        // keep the mirror of task placement in step with well-formed requests
        case (req)
            REQ_ADD:
            begin
                lvl_of[t] = p;
                linked[t] = 1;
            end
            REQ_REMOVE:  if (lvl_of[t] == p) lvl_of[t] = -1;
            REQ_REQUEUE:
            begin
                lvl_of[t] = np;
                linked[t] = 1;
            end
            REQ_DEQ:     if (r.found) lvl_of[r.tid] = -1;
            default: ;
        endcase
        g = gap_len();
        if (g > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    // Sender pauses: no word on offer until every owed response is back.
    task wait_drained();
        s_tvalid <= 1'b0;
        while (sb.owed.size() != 0)
            @(posedge clk);
    endtask

    function int pick_queued();
        int t;
        for (int i = 0; i < 16; i++)
        begin
            t = $urandom_range(0, 63);
            if (lvl_of[t] >= 0)
                return t;
        end
        return -1;
    endfunction

    function int pick_free();
        int t;
        for (int i = 0; i < 16; i++)
        begin
            t = $urandom_range(0, 63);
            if (lvl_of[t] < 0)
                return t;
        end
        return $urandom_range(0, 63);
    endfunction

    function int pick_linked();
        int t;
        for (int i = 0; i < 32; i++)
        begin
            t = $urandom_range(0, 63);
            if (linked[t])
                return t;
        end
        return -1;
    endfunction

    function int rand_level();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 0;
        if (r == 1) return 31;
        return $urandom_range(0, 31);
    endfunction

    // One random request; mostly well-formed list traffic, some broken ones.
    task random_request();
        int r, t, p, np, ps;
        r = $urandom_range(0, 99);
        p = rand_level();
        np = rand_level();
        ps = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 12);
        t = $urandom_range(0, 63);
        if (r < 30)
            send_request(REQ_ADD, pick_free(), p, np, ps);
        else if (r < 52)
        begin
            t = pick_queued();
            if (t < 0)
                send_request(REQ_DEQ, $urandom_range(0, 63), p, np, ps);
            else if (r < 42)
                send_request(REQ_REMOVE, t, lvl_of[t], np, ps);
            else
                send_request(REQ_REQUEUE, t, lvl_of[t], np, ps);
        end
        else if (r < 64)
            send_request(REQ_DEQ, t, p, np, ps);
        else if (r < 72)
            send_request(REQ_PEEK, t, p, np, ps);
        else if (r < 82)
            send_request(REQ_POS, t, p, np, ps);
        else if (r < 92)
            send_request(REQ_WBF, t, p, np, ps);
        else if (r < 95)
            send_request(REQ_UNUSED, t, p, np, ps);
        else
        begin
            // broken traffic: wrong level, or a task added twice
            t = pick_linked();
            if (t < 0 || r == 99)
                send_request(REQ_ADD, t < 0 ? pick_free() : t, p, np, ps);
            else if (r < 97)
                send_request(REQ_REMOVE, t, p, np, ps);
            else
                send_request(REQ_REQUEUE, t, p, np, ps);
        end
    endtask

    // Empty the queue by dequeues, bounded in case the lists hold a cycle.
    task drain_queue();
        for (int i = 0; i < 70 && sb.top_level() >= 0; i++)
            send_request(REQ_DEQ, $urandom_range(0, 63), 0, 0, 0);
        foreach (lvl_of[i]) lvl_of[i] = -1;
    endtask

    // Receiver: random stalls, plus one long hold-off when asked.
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_rx)
            begin
                m_tready <= 1'b0;
                repeat (400) @(posedge clk);
                hold_rx = 0;
            end
            m_tready <= (calm || gap_len() == 0);
            @(posedge clk);
            if (m_tvalid && m_tready)
                sb.check_response(resp_t'(m_tdata[8:0]));
        end
    end

    initial
    begin
        #5000000;
        $display("FAIL priority_bitmap_ready_queue");
        $finish;
    end

    initial
    begin
        sb = new();
        foreach (lvl_of[i]) lvl_of[i] = -1;
        hold_rx = 0;
        calm = 0;
        n_sent = 0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty-queue answers, level extremes, every request kind
        send_request(REQ_PEEK, 0, 0, 0, 0);
        send_request(REQ_DEQ, 63, 31, 31, 63);
        send_request(REQ_POS, 0, 0, 0, 0);
        send_request(REQ_WBF, 0, 0, 0, 0);
        send_request(REQ_UNUSED, 63, 31, 31, 63);
        send_request(REQ_ADD, 0, 0, 0, 0);
        send_request(REQ_ADD, 63, 31, 0, 0);
        send_request(REQ_ADD, 5, 31, 0, 0);
        send_request(REQ_ADD, 9, 0, 0, 0);
        send_request(REQ_WBF, 0, 31, 0, 0);
        send_request(REQ_POS, 0, 0, 0, 0);
        send_request(REQ_POS, 0, 0, 0, 3);
        send_request(REQ_POS, 0, 0, 0, 4);
        send_request(REQ_POS, 0, 0, 0, 63);
        send_request(REQ_REQUEUE, 5, 31, 0, 0);
        send_request(REQ_PEEK, 0, 0, 0, 0);
        send_request(REQ_REMOVE, 63, 31, 0, 0);
        send_request(REQ_WBF, 0, 1, 0, 0);
        send_request(REQ_DEQ, 0, 0, 0, 0);
        send_request(REQ_REMOVE, 63, 31, 0, 0);   // level already empty
        send_request(REQ_REQUEUE, 63, 31, 17, 0); // from an empty level
        send_request(REQ_DEQ, 0, 0, 0, 0);
        send_request(REQ_DEQ, 0, 0, 0, 0);
        send_request(REQ_DEQ, 0, 0, 0, 0);
        send_request(REQ_DEQ, 0, 0, 0, 0);

        for (int i = 0; i < 1430; i++)
        begin
            if (i % 200 == 0)
                calm = !calm;
            if (i == 500)
                hold_rx = 1;
            if (i == 900)
                wait_drained();
            if (i % 300 == 299)
                drain_queue();
            random_request();
        end

        s_tvalid <= 1'b0;
        wait_drained();
        repeat (150) @(posedge clk);
        if (sb.errors == 0 && sb.owed.size() == 0)
            $display("PASS priority_bitmap_ready_queue");
        else
            $display("FAIL priority_bitmap_ready_queue");
        $finish;
    end

endmodule
`default_nettype wire

### sim.f
+incdir+rtl/core
rtl/core/pbrq_pkg.sv
rtl/core/pbrq_ram.sv
rtl/core/pbrq_top_enc.sv
rtl/core/priority_bitmap_ready_queue.sv
dv/tb_priority_bitmap_ready_queue.sv
